### hw/rtl/srrft_pkg.sv
// ----------------------------------------------------------------------------
// srrft_pkg
// Shared constants, codes and types of the sticky round-robin flow table.
// ----------------------------------------------------------------------------
package srrft_pkg;

    localparam int SESSIONS = 64;
    localparam int TARGETS  = 16;

    localparam int IDX_W  = $clog2(SESSIONS);
    localparam int CNT_W  = $clog2(SESSIONS + 1);
    localparam int TGT_W  = 4;
    localparam int NUMT_W = 5;
    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int KEY_W  = ADDR_W + PORT_W;
    localparam int TIME_W = 32;
    localparam int LIM_W  = 16;
    localparam int EVC_W  = 7;

    localparam logic [LIM_W-1:0]  DEFAULT_IDLE_LIMIT = 16'd900;
    localparam logic [NUMT_W-1:0] TARGETS_N          = NUMT_W'(TARGETS);
    localparam logic [EVC_W-1:0]  EVICT_MAX          = 7'd127;

    // Input action codes.
    localparam logic [1:0] ACT_SOURCE = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_REPLY  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_ENABLE  = 2'd0;
    localparam logic [1:0] REG_TARGETS = 2'd1;
    localparam logic [1:0] REG_IDLE    = 2'd2;

    typedef enum logic
    {
        CMP_KEY = 1'b0,
        CMP_AGE = 1'b1
    } cmp_mode_t;

    typedef struct packed
    {
        cmp_mode_t         mode;
        logic [KEY_W-1:0]  a;
        logic [KEY_W-1:0]  b;
        logic [LIM_W-1:0]  limit;
    } cmp_in_t;

    typedef struct packed
    {
        logic              forwarded;
        logic [TGT_W-1:0]  target_index;
        logic [IDX_W-1:0]  slot;
        logic              new_session;
        logic              dropped;
        logic [ADDR_W-1:0] peer_addr;
        logic [PORT_W-1:0] peer_port;
        logic [EVC_W-1:0]  evicted_count;
    } res_t;

endpackage

### hw/rtl/srrft_ram.sv
// ----------------------------------------------------------------------------
// srrft_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module srrft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/srrft_cmp.sv
// ----------------------------------------------------------------------------
// srrft_cmp
// Shared compare unit: key equality for lookups, idle age against the limit
// for the eviction sweep.
// ----------------------------------------------------------------------------
module srrft_cmp
    import srrft_pkg::*;
(
    input  cmp_in_t cmp_in,
    output logic    match
);

    logic [TIME_W-1:0] age;

    assign age = cmp_in.a[TIME_W-1:0] - cmp_in.b[TIME_W-1:0];

    always_comb
    begin
        case (cmp_in.mode)
            CMP_KEY: match = (cmp_in.a == cmp_in.b);
            CMP_AGE: match = (age >= {{(TIME_W-LIM_W){1'b0}}, cmp_in.limit});
            default: match = 1'b0;
        endcase
    end

endmodule

### hw/rtl/sticky_round_robin_flow_table.sv
// ----------------------------------------------------------------------------
// sticky_round_robin_flow_table
// Session table of a sticky UDP load balancer with round-robin target choice
// and idle eviction on a one-second tick.
// ----------------------------------------------------------------------------
//  Channel   Handshake                      Contents
//  input     in_valid / in_ready            action, src_addr, src_port, slot_in
//  result    out_valid / out_ready          forwarded ... evicted_count
//  config    psel, penable, pwrite, pready  enable, num_targets, idle limit
//
// An enabled source packet or an enabled tick sweeps all SESSIONS slots through
// the shared compare unit, one RAM read per cycle, then ST_FINISH and ST_DONE.
// A forwarded reply passes through ST_REPLY to ST_DONE; a disabled packet, a
// dropped reply, a disabled tick or an unused action goes straight to ST_DONE.
// Reset clears the valid bits at once; no clearing pass is needed.
// A result waits in the output register; the next item is taken once the
// sequencer is back in idle.
// ----------------------------------------------------------------------------
module sticky_round_robin_flow_table
    import srrft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        action,
    input  logic [ADDR_W-1:0] src_addr,
    input  logic [PORT_W-1:0] src_port,
    input  logic [IDX_W-1:0]  slot_in,

    output logic              out_valid,
    input  logic              out_ready,
    output logic              forwarded,
    output logic [TGT_W-1:0]  target_index,
    output logic [IDX_W-1:0]  slot,
    output logic              new_session,
    output logic              dropped,
    output logic [ADDR_W-1:0] peer_addr,
    output logic [PORT_W-1:0] peer_port,
    output logic [EVC_W-1:0]  evicted_count,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [4:0]
    {
        ST_IDLE   = 5'b00001,
        ST_SWEEP  = 5'b00010,
        ST_FINISH = 5'b00100,
        ST_REPLY  = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [SESSIONS-1:0] valid_reg, valid_next;
    logic                enable_reg, enable_next;
    logic [NUMT_W-1:0]   num_reg, num_next;
    logic [LIM_W-1:0]    idle_reg, idle_next;
    logic [TGT_W-1:0]    rr_reg, rr_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic                hit_reg, hit_next;
    logic                free_reg, free_next;
    logic [EVC_W-1:0]    evict_reg, evict_next;
    logic                out_valid_reg, out_valid_next;

    logic [KEY_W-1:0]    pkt_key_reg, pkt_key_next;
    logic [IDX_W-1:0]    slot_in_reg, slot_in_next;
    logic [IDX_W-1:0]    hit_slot_reg, hit_slot_next;
    logic [TGT_W-1:0]    hit_tgt_reg, hit_tgt_next;
    logic [IDX_W-1:0]    free_slot_reg, free_slot_next;
    res_t                work_res_reg, work_res_next;
    res_t                out_res_reg, out_res_next;

    logic                     cfg_we;
    logic [IDX_W-1:0]         rd_addr;
    logic                     key_we;
    logic [IDX_W-1:0]         key_waddr;
    logic [TGT_W+KEY_W-1:0]   key_wdata;
    logic [TGT_W+KEY_W-1:0]   key_rdata;
    logic                     seen_we;
    logic [IDX_W-1:0]         seen_waddr;
    logic [TIME_W-1:0]        seen_rdata;
    cmp_in_t                  cmp_in;
    logic                     cmp_match;
    logic [NUMT_W-1:0]        tcount;
    logic [TGT_W-1:0]         rr_pick;
    logic [LIM_W-1:0]         limit_eff;

    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    assign forwarded     = out_res_reg.forwarded;
    assign target_index  = out_res_reg.target_index;
    assign slot          = out_res_reg.slot;
    assign new_session   = out_res_reg.new_session;
    assign dropped       = out_res_reg.dropped;
    assign peer_addr     = out_res_reg.peer_addr;
    assign peer_port     = out_res_reg.peer_port;
    assign evicted_count = out_res_reg.evicted_count;

    always_comb
    begin
        case (paddr[3:2])
            REG_ENABLE:  prdata = {31'b0, enable_reg};
            REG_TARGETS: prdata = {{(32-NUMT_W){1'b0}}, num_reg};
            REG_IDLE:    prdata = {{(32-LIM_W){1'b0}}, idle_reg};
            default:     prdata = 32'b0;
        endcase
    end

    assign limit_eff = (idle_reg == '0) ? LIM_W'(1) : idle_reg;
    assign tcount    = (num_reg == '0) ? NUMT_W'(1) :
                       ((num_reg > TARGETS_N) ? TARGETS_N : num_reg);
    assign rr_pick   = ({1'b0, rr_reg} < tcount) ? rr_reg : '0;

    assign rd_addr = (state_reg == ST_IDLE) ? slot_in : cnt_reg[IDX_W-1:0];

    srrft_ram #(
        .WIDTH(TGT_W + KEY_W),
        .DEPTH(SESSIONS)
    ) u_key_ram (
        .clk  (clk),
        .we   (key_we),
        .waddr(key_waddr),
        .wdata(key_wdata),
        .raddr(rd_addr),
        .rdata(key_rdata)
    );

    srrft_ram #(
        .WIDTH(TIME_W),
        .DEPTH(SESSIONS)
    ) u_seen_ram (
        .clk  (clk),
        .we   (seen_we),
        .waddr(seen_waddr),
        .wdata(now_reg),
        .raddr(rd_addr),
        .rdata(seen_rdata)
    );

    always_comb
    begin
        if (op_reg == ACT_TICK)
        begin
            cmp_in.mode = CMP_AGE;
            cmp_in.a    = {{(KEY_W-TIME_W){1'b0}}, now_reg};
            cmp_in.b    = {{(KEY_W-TIME_W){1'b0}}, seen_rdata};
        end
        else
        begin
            cmp_in.mode = CMP_KEY;
            cmp_in.a    = key_rdata[KEY_W-1:0];
            cmp_in.b    = pkt_key_reg;
        end
        cmp_in.limit = limit_eff;
    end

    srrft_cmp u_cmp (
        .cmp_in(cmp_in),
        .match (cmp_match)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = cnt_reg[IDX_W-1:0];
        valid_next     = valid_reg;
        enable_next    = enable_reg;
        num_next       = num_reg;
        idle_next      = idle_reg;
        rr_next        = rr_reg;
        now_next       = now_reg;
        hit_next       = hit_reg;
        free_next      = free_reg;
        evict_next     = evict_reg;
        out_valid_next = out_valid_reg;
        pkt_key_next   = pkt_key_reg;
        slot_in_next   = slot_in_reg;
        hit_slot_next  = hit_slot_reg;
        hit_tgt_next   = hit_tgt_reg;
        free_slot_next = free_slot_reg;
        work_res_next  = work_res_reg;
        out_res_next   = out_res_reg;
        key_we         = 1'b0;
        key_waddr      = free_slot_reg;
        key_wdata      = {rr_pick, pkt_key_reg};
        seen_we        = 1'b0;
        seen_waddr     = free_slot_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = action;
                    pkt_key_next  = {src_addr, src_port};
                    slot_in_next  = slot_in;
                    work_res_next = '0;
                    cnt_next      = '0;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    evict_next    = '0;
                    state_next    = ST_DONE;
                    case (action)
                        ACT_SOURCE:
                        begin
                            if (enable_reg)
                            begin
                                state_next = ST_SWEEP;
                            end
                            else
                            begin
                                work_res_next.dropped = 1'b1;
                            end
                        end
                        ACT_TICK:
                        begin
                            now_next = now_reg + 1'b1;
                            if (enable_reg)
                            begin
                                state_next = ST_SWEEP;
                            end
                        end
                        ACT_REPLY:
                        begin
                            if (enable_reg && valid_reg[slot_in])
                            begin
                                state_next = ST_REPLY;
                            end
                            else
                            begin
                                work_res_next.dropped = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SWEEP:
            begin
                if (cnt_reg < CNT_W'(SESSIONS))
                begin
                    cnt_next     = cnt_reg + 1'b1;
                    chk_vld_next = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
                if (chk_vld_reg)
                begin
                    if (op_reg == ACT_TICK)
                    begin
                        if (valid_reg[chk_idx_reg] && cmp_match)
                        begin
                            valid_next[chk_idx_reg] = 1'b0;
                            if (evict_reg != EVICT_MAX)
                            begin
                                evict_next = evict_reg + 1'b1;
                            end
                        end
                    end
                    else if (valid_reg[chk_idx_reg])
                    begin
                        if (!hit_reg && cmp_match)
                        begin
                            hit_next      = 1'b1;
                            hit_slot_next = chk_idx_reg;
                            hit_tgt_next  = key_rdata[TGT_W+KEY_W-1:KEY_W];
                        end
                    end
                    else if (!free_reg)
                    begin
                        free_next      = 1'b1;
                        free_slot_next = chk_idx_reg;
                    end
                end
            end

            ST_FINISH:
            begin
                state_next = ST_DONE;
                if (op_reg == ACT_TICK)
                begin
                    work_res_next.evicted_count = evict_reg;
                end
                else if (hit_reg)
                begin
                    seen_we                    = 1'b1;
                    seen_waddr                 = hit_slot_reg;
                    work_res_next.forwarded    = 1'b1;
                    work_res_next.target_index = hit_tgt_reg;
                    work_res_next.slot         = hit_slot_reg;
                end
                else if (!free_reg)
                begin
                    work_res_next.dropped = 1'b1;
                end
                else
                begin
                    key_we                       = 1'b1;
                    seen_we                      = 1'b1;
                    valid_next[free_slot_reg]    = 1'b1;
                    rr_next = ({1'b0, rr_pick} + 1'b1 == tcount) ? '0 : rr_pick + 1'b1;
                    work_res_next.forwarded    = 1'b1;
                    work_res_next.target_index = rr_pick;
                    work_res_next.slot         = free_slot_reg;
                    work_res_next.new_session  = 1'b1;
                end
            end

            ST_REPLY:
            begin
                state_next              = ST_DONE;
                work_res_next.forwarded = 1'b1;
                work_res_next.slot      = slot_in_reg;
                work_res_next.peer_addr = key_rdata[KEY_W-1:PORT_W];
                work_res_next.peer_port = key_rdata[PORT_W-1:0];
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_res_next   = work_res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (paddr[3:2])
                REG_ENABLE:
                begin
                    enable_next = pwdata[0];
                    if (!pwdata[0])
                    begin
                        valid_next = '0;
                    end
                end
                REG_TARGETS: num_next  = pwdata[NUMT_W-1:0];
                REG_IDLE:    idle_next = pwdata[LIM_W-1:0];
                default:     enable_next = enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= ACT_SOURCE;
            cnt_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            valid_reg     <= '0;
            enable_reg    <= 1'b0;
            num_reg       <= NUMT_W'(1);
            idle_reg      <= DEFAULT_IDLE_LIMIT;
            rr_reg        <= '0;
            now_reg       <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            evict_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            chk_vld_reg   <= chk_vld_next;
            valid_reg     <= valid_next;
            enable_reg    <= enable_next;
            num_reg       <= num_next;
            idle_reg      <= idle_next;
            rr_reg        <= rr_next;
            now_reg       <= now_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            evict_reg     <= evict_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        pkt_key_reg   <= pkt_key_next;
        slot_in_reg   <= slot_in_next;
        hit_slot_reg  <= hit_slot_next;
        hit_tgt_reg   <= hit_tgt_next;
        free_slot_reg <= free_slot_next;
        work_res_reg  <= work_res_next;
        out_res_reg   <= out_res_next;
    end

`ifndef ASSERT_OFF
    a_chk_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> (state_reg == ST_SWEEP))
        else $error("Sweep check pending outside the sweep.");

    a_disable_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (paddr[3:2] == REG_ENABLE) && !pwdata[0]) |=> (valid_reg == '0))
        else $error("Sessions survived a disable write.");

    a_new_forwarded: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && new_session) |-> (forwarded && !dropped))
        else $error("New session item not marked as forwarded.");

    a_evict_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (evicted_count != '0)) |-> (!forwarded && !dropped))
        else $error("Eviction count on a forwarded or dropped item.");
`endif

endmodule
